>>> design/dwsh_pkg.sv
// Shared types and constants of the dual word string hash unit.
`default_nettype none
package dwsh_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned WordW = 32;
  localparam int unsigned LenW  = 16;

  // Hash multipliers and rotate amounts.
  localparam logic [WordW-1:0] MulA = 32'd2170698181;
  localparam logic [WordW-1:0] MulB = 32'd73762243;
  localparam int unsigned      RotA = 13;
  localparam int unsigned      RotB = 7;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [WordW-1:0] fold_a;   // low half XOR high half of word * MulA
    logic [WordW-1:0] prod_b;   // low half of word * MulB
    logic [LenW-1:0]  len;      // masked string length, used on a first word
    logic             first;
    logic             last;
  } entry_t;

  // Rotate right by a constant amount.
  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x,
                                            input int unsigned r);
    rotr = (x >> r) | (x << (WordW - r));
  endfunction

endpackage
`default_nettype wire

>>> design/dwsh_front.sv
// Front end: accepts word requests, masks the length and forms both products.
`default_nettype none
module dwsh_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [dwsh_pkg::WordW-1:0] data_word_i,
  input  wire logic                      begins_string_i,
  input  wire logic [dwsh_pkg::LenW-1:0] string_length_i,
  input  wire logic                      ends_string_i,
  output logic                           push_valid_o,
  input  wire logic                      push_ready_i,
  output dwsh_pkg::entry_t               push_entry_o
);
  import dwsh_pkg::*;

  // Length is taken modulo 2^LENGTH_BITS.
  localparam logic [LenW-1:0] LenMask =
    (LENGTH_BITS >= LenW) ? {LenW{1'b1}} : LenW'((64'd1 << LENGTH_BITS) - 64'd1);

  logic             valid_q, valid_d;
  logic [WordW-1:0] word_q;
  logic [LenW-1:0]  len_q;
  logic             first_q, last_q;
  logic [2*WordW-1:0] prod_a;
  logic [WordW-1:0]   prod_b;

  // The input register is free when empty or when its request moves on.
  assign in_ready_o = !valid_q || push_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q  <= data_word_i;
      len_q   <= string_length_i & LenMask;
      first_q <= begins_string_i;
      last_q  <= ends_string_i;
    end
  end

  // Both multiplies sit between the input register and the queue.
  assign prod_a = (2*WordW)'(word_q) * (2*WordW)'(MulA);
  assign prod_b = word_q * MulB;

  assign push_valid_o        = valid_q;
  assign push_entry_o.fold_a = prod_a[WordW-1:0] ^ prod_a[2*WordW-1:WordW];
  assign push_entry_o.prod_b = prod_b;
  assign push_entry_o.len    = len_q;
  assign push_entry_o.first  = first_q;
  assign push_entry_o.last   = last_q;

endmodule
`default_nettype wire

>>> design/dwsh_fifo.sv
// Short queue of classified words between the front and the back.
`default_nettype none
module dwsh_fifo #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire dwsh_pkg::entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output dwsh_pkg::entry_t      pop_entry_o
);
  import dwsh_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  entry_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

>>> design/dwsh_back.sv
// Back end: runs the rotate and XOR recurrences and holds the result register.
`default_nettype none
module dwsh_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pop_valid_i,
  output logic                            pop_ready_o,
  input  wire dwsh_pkg::entry_t           pop_entry_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [dwsh_pkg::WordW-1:0]      hash_a_o,
  output logic [dwsh_pkg::WordW-1:0]      hash_b_o
);
  import dwsh_pkg::*;

  logic [WordW-1:0] run_a_q, run_a_d;
  logic [WordW-1:0] run_b_q, run_b_d;
  logic [WordW-1:0] seed_a, seed_b;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] hash_a_q, hash_b_q;
  logic             pop;

  // A word leaves the queue whenever the result register can take a result.
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  // A first word seeds A with minus the length and B with the length.
  always_comb begin
    seed_a = run_a_q;
    seed_b = run_b_q;
    if (pop_entry_i.first) begin
      seed_a = '0 - WordW'(pop_entry_i.len);
      seed_b = WordW'(pop_entry_i.len);
    end
    run_a_d = rotr(seed_a, RotA) ^ pop_entry_i.fold_a;
    run_b_d = rotr(seed_b, RotB) ^ pop_entry_i.prod_b;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && pop_entry_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_a_q     <= '0;
      run_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        run_a_q <= run_a_d;
        run_b_q <= run_b_d;
      end
    end
  end

  // Result payload is loaded on the tail word.
  always_ff @(posedge clk_i) begin
    if (pop && pop_entry_i.last) begin
      hash_a_q <= run_a_d;
      hash_b_q <= run_b_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_a_o    = hash_a_q;
  assign hash_b_o    = hash_b_q;

endmodule
`default_nettype wire

>>> design/dual_word_string_hash_unit.sv
// Top level of the dual word string hash unit.
// The unit takes one 32-bit word request per cycle and keeps that rate as long
// as results are taken. A word passes through the input register, where both
// constant multiplies are formed, into a FIFO_DEPTH-entry queue, and then into
// the back end, which applies one rotate-and-XOR step per cycle to each hash.
// A result is registered in the result register once its tail word has passed the
// input register and the queue. When results stall, the queue absorbs words until
// it and the input register fill, after which in_ready_o drops. Lengths are taken
// modulo 2^LENGTH_BITS; running hashes reset to zero.
`default_nettype none
module dual_word_string_hash_unit #(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned FIFO_DEPTH  = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [dwsh_pkg::WordW-1:0] data_word_i,
  input  wire logic                       begins_string_i,
  input  wire logic [dwsh_pkg::LenW-1:0]  string_length_i,
  input  wire logic                       ends_string_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [dwsh_pkg::WordW-1:0]      hash_a_o,
  output logic [dwsh_pkg::WordW-1:0]      hash_b_o
);
  import dwsh_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  // Request intake and products.
  dwsh_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_word_i    (data_word_i),
    .begins_string_i(begins_string_i),
    .string_length_i(string_length_i),
    .ends_string_i  (ends_string_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_entry_o   (push_entry)
  );

  // Decoupling queue.
  dwsh_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_entry_o (pop_entry)
  );

  // Hash recurrences and result register.
  dwsh_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_entry_i(pop_entry),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hash_a_o   (hash_a_o),
    .hash_b_o   (hash_b_o)
  );

endmodule
`default_nettype wire

>>> design/dwsh_checker.sv
// Port-level checker of the dual word string hash unit and its bind.
`default_nettype none
module dwsh_checker #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       ends_string_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [dwsh_pkg::WordW-1:0] hash_a_o,
  input wire logic [dwsh_pkg::WordW-1:0] hash_b_o
);
  import dwsh_pkg::*;

  // Requests in flight: input register, queue and result register.
  localparam int unsigned Cap   = FIFO_DEPTH + 2;
  localparam int unsigned PendW = $clog2(Cap + 2) + 1;

  logic [PendW-1:0] pend_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Count tail words accepted but whose results are not yet taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && ends_string_i && !out_acc) begin
      pend_q <= pend_q + PendW'(1);
    end else if (out_acc && !(in_acc && ends_string_i)) begin
      pend_q <= pend_q - PendW'(1);
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_a_o) && $stable(hash_b_o))
    else $error("result changed while stalled");

  // No result without an earlier tail word.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending tail word");

  // Backpressure keeps pending results within the storage.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(Cap))
    else $error("more pending results than storage");

endmodule

bind dual_word_string_hash_unit dwsh_checker #(
  .FIFO_DEPTH(FIFO_DEPTH)
) u_dwsh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .ends_string_i(ends_string_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_a_o     (hash_a_o),
  .hash_b_o     (hash_b_o)
);
`default_nettype wire

>>> tb/tb_dual_word_string_hash_unit.sv
// Self-checking testbench for the dual word string hash unit.
module tb_dual_word_string_hash_unit;
  import dwsh_pkg::*;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;

  // Ways of filling the bytes of a string.
  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } fill_e;

  // One predicted pair of hashes.
  typedef struct {
    logic [WordW-1:0] hash_a;
    logic [WordW-1:0] hash_b;
  } hash_pair_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [WordW-1:0] data_word_i     = '0;
  logic             begins_string_i = 1'b0;
  logic [LenW-1:0]  string_length_i = '0;
  logic             ends_string_i   = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [WordW-1:0] hash_a_o;
  logic [WordW-1:0] hash_b_o;

  // Predictor state and bookkeeping.
  logic [WordW-1:0] model_hash_a = '0;
  logic [WordW-1:0] model_hash_b = '0;
  hash_pair_t       pending_hashes[$];
  int unsigned      mismatch_count = 0;
  int unsigned      words_sent     = 0;
  int unsigned      strings_sent   = 0;
  int unsigned      hashes_checked = 0;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_idle_pct  = 0;

  dual_word_string_hash_unit #(
    .LENGTH_BITS(LENGTH_BITS),
    .FIFO_DEPTH (4)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_word_i    (data_word_i),
    .begins_string_i(begins_string_i),
    .string_length_i(string_length_i),
    .ends_string_i  (ends_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hash_a_o       (hash_a_o),
    .hash_b_o       (hash_b_o)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Rotate right by n, done on a doubled copy of the value.
  function automatic logic [WordW-1:0] rotate_right(input logic [WordW-1:0] x,
                                                    input int unsigned n);
    logic [2*WordW-1:0] doubled;
    doubled = {x, x} >> n;
    return doubled[WordW-1:0];
  endfunction

  // Advance both running hashes by one accepted request.
  task automatic predict_request(input logic [WordW-1:0] word, input logic first,
                                 input logic [LenW-1:0] len, input logic last);
    logic [2*WordW-1:0] prod_a;
    logic [2*WordW-1:0] prod_b;
    logic [WordW-1:0]   len_masked;
    hash_pair_t         pair;
    len_masked = WordW'(len);
    if (LENGTH_BITS < WordW) len_masked &= (32'd1 << LENGTH_BITS) - 32'd1;
    if (first) begin
      model_hash_a = 32'd0 - len_masked;
      model_hash_b = len_masked;
    end
    prod_a = {32'd0, word} * {32'd0, MulA};
    prod_b = {32'd0, word} * {32'd0, MulB};
    model_hash_a = rotate_right(model_hash_a, RotA) ^ (prod_a[31:0] ^ prod_a[63:32]);
    model_hash_b = rotate_right(model_hash_b, RotB) ^ prod_b[31:0];
    if (last) begin
      pair.hash_a = model_hash_a;
      pair.hash_b = model_hash_b;
      pending_hashes.insert(pending_hashes.size(), pair);
    end
  endtask

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %08h, expected %08h", what, got, want);
  endtask

  // Result checks come before prediction so that a result never meets its own request.
  always @(posedge clk_i) begin
    hash_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch("result with no request waiting, hash_a", hash_a_o, '0);
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (hash_a_o !== want.hash_a) report_mismatch("hash_a", hash_a_o, want.hash_a);
        if (hash_b_o !== want.hash_b) report_mismatch("hash_b", hash_b_o, want.hash_b);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_request(data_word_i, begins_string_i, string_length_i, ends_string_i);
    end
  end

  // Random backpressure on the result side.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("dual_word_string_hash_unit verification failed");
    $finish;
  end

  // Send one word request, with random idle cycles in front of it.
  task automatic send_word(input logic [WordW-1:0] word, input logic first,
                           input logic [LenW-1:0] len, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_word_i     <= word;
    begins_string_i <= first;
    string_length_i <= len;
    ends_string_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  function automatic logic [WordW-1:0] fill_word(input fill_e fill);
    case (fill)
      FILL_ONES:  return '1;
      FILL_ZEROS: return '0;
      default:    return $urandom;
    endcase
  endfunction

  // Send a well-formed string: the full words first, then the tail.
  task automatic send_string(input int unsigned len, input fill_e fill);
    int unsigned      full_words;
    int unsigned      tail_bytes;
    logic [WordW-1:0] tail_mask;
    full_words = len / 4;
    tail_bytes = len % 4;
    for (int unsigned k = 0; k < full_words; k++) begin
      send_word(fill_word(fill), k == 0,
                (k == 0) ? LenW'(len) : LenW'($urandom_range(65535)), 1'b0);
    end
    tail_mask = (tail_bytes == 0) ? '0 : (32'hFFFF_FFFF >> (8 * (4 - tail_bytes)));
    send_word(fill_word(fill) & tail_mask, full_words == 0,
              (full_words == 0) ? LenW'(len) : LenW'($urandom_range(65535)), 1'b1);
    strings_sent++;
  endtask

  // Words arriving right after reset with no first word start from zero hashes.
  task automatic test_words_after_reset();
    send_word(32'h1234_5678, 1'b0, 16'hFFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0);
    send_word(32'h0000_0000, 1'b0, 16'h5A5A, 1'b1);
  endtask

  // Strings of zero to three bytes, where the first word is also the last.
  task automatic test_short_strings();
    send_string(0, FILL_RANDOM);
    send_string(1, FILL_ONES);
    send_string(2, FILL_RANDOM);
    send_string(3, FILL_ONES);
    send_string(3, FILL_ZEROS);
  endtask

  // Word and length extremes in well-formed strings.
  task automatic test_field_extremes();
    send_string(4, FILL_ONES);
    send_string(8, FILL_ZEROS);
    send_string(7, FILL_ONES);
  endtask

  // Length fields that disagree with the word count, and words after a last word.
  task automatic test_irregular_sequences();
    send_word(32'hDEAD_BEEF, 1'b1, 16'hFFFF, 1'b0);
    send_word(32'h8000_0001, 1'b0, 16'h0000, 1'b1);
    // Words that continue from the emitted hashes.
    send_word(32'hFFFF_FFFF, 1'b0, 16'hAAAA, 1'b0);
    send_word(32'h0000_0001, 1'b0, 16'h5555, 1'b1);
    // A new first word in the middle of a string restarts it.
    send_word(32'hCAFE_F00D, 1'b1, 16'h0010, 1'b0);
    send_word(32'h0F0F_0F0F, 1'b1, 16'h8000, 1'b0);
    send_word(32'h0000_00FF, 1'b0, 16'h0001, 1'b1);
  endtask

  // Mostly well-formed strings with random content, plus noise and broken strings.
  task automatic test_random_strings(input int unsigned word_target);
    int unsigned start;
    int unsigned pick;
    int unsigned extra;
    start = words_sent;
    while (words_sent - start < word_target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_string($urandom_range(24), FILL_RANDOM);
      end else if (pick < 80) begin
        send_string($urandom_range(25, 120), ($urandom_range(1) != 0) ? FILL_ONES : FILL_RANDOM);
      end else if (pick < 90) begin
        send_word($urandom, 1'($urandom_range(1)), LenW'($urandom_range(65535)),
                  1'($urandom_range(1)));
      end else begin
        // Broken string: arbitrary length field, a few words, maybe no last word.
        extra = $urandom_range(3);
        send_word($urandom, 1'b1, LenW'($urandom_range(65535)), 1'b0);
        for (int unsigned k = 0; k < extra; k++) begin
          send_word($urandom, 1'b0, LenW'($urandom_range(65535)), 1'b0);
        end
        if ($urandom_range(1) != 0) begin
          send_word($urandom, 1'b0, LenW'($urandom_range(65535)), 1'b1);
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 71;
    test_words_after_reset();
    test_short_strings();
    test_field_extremes();
    test_irregular_sequences();
    test_random_strings(430);

    send_idle_pct = 71;
    recv_idle_pct = 8;
    test_random_strings(430);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(430);

    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d word requests in %0d well-formed strings plus noise and broken strings.",
             words_sent, strings_sent);
    $display("Checked %0d hash results under three flow-control patterns, %0d mismatches.",
             hashes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("dual_word_string_hash_unit verification clean");
    end else begin
      $display("dual_word_string_hash_unit verification failed");
    end
    $finish;
  end

endmodule
